// ===== sv/mptd_pkg.sv =====
// Shared types, codes and default sizes of the multilevel priority task dispatcher.
package mptd_pkg;

	localparam int DEF_NUM_LEVELS = 8;
	localparam int DEF_NUM_TASKS = 16;

	localparam int ACTION_W = 2;
	localparam int TASK_W = 4;
	localparam int LEVEL_W = 4;
	localparam int STATUS_W = 2;
	localparam int HLEVEL_W = 3;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SCHEDULE = 2'd0,
		ACT_DISPATCH = 2'd1,
		ACT_COMPLETE = 2'd2,
		ACT_QUERY    = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 2'd0,
		STS_RANGE = 2'd1,
		STS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		RES_OK,
		RES_RANGE,
		RES_EMPTY,
		RES_QUERY,
		RES_RUN
	} res_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_POP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic     load_in;
		logic     enqueue;
		logic     enq_from_task;
		logic     jump;
		logic     query;
		logic     scan_step;
		logic     pop_take;
		logic     res_we;
		res_sel_t res_sel;
		logic     deliver;
	} dp_cmd_t;

	typedef struct packed {
		action_t action;
		logic    task_oor;
		logic    level_oor;
		logic    more;
		logic    queue_empty;
		logic    scan_pop;
		logic    pop_pending;
		logic    out_busy;
	} dp_stat_t;

endpackage

// ===== sv/mptd_ctrl.sv =====
// Controller state machine that sequences each beat through the dispatcher datapath.
module mptd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mptd_pkg::dp_stat_t stat,
	output mptd_pkg::dp_cmd_t  cmd
);
	import mptd_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.action == ACT_DISPATCH && !stat.queue_empty) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				if (stat.scan_pop) begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				if (stat.pop_pending) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_DONE: begin
				if (!stat.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load_in = in_valid;
			end
			ST_EXEC: begin
				cmd.res_we = 1'b1;
				cmd.res_sel = RES_OK;
				if (stat.action == ACT_DISPATCH) begin
					// A dispatch with work queued gets its result from the scan.
					if (stat.queue_empty) begin
						cmd.res_sel = RES_EMPTY;
					end else begin
						cmd.res_we = 1'b0;
					end
				end else if (stat.task_oor) begin
					cmd.res_sel = RES_EMPTY;
				end else begin
					case (stat.action)
						ACT_SCHEDULE: begin
							if (stat.level_oor) begin
								cmd.res_sel = RES_RANGE;
							end else begin
								cmd.enqueue = 1'b1;
							end
						end
						ACT_COMPLETE: begin
							if (stat.more) begin
								cmd.enqueue = 1'b1;
								cmd.enq_from_task = 1'b1;
								cmd.jump = 1'b1;
							end
						end
						ACT_QUERY: begin
							if (stat.level_oor) begin
								cmd.res_sel = RES_RANGE;
							end else begin
								cmd.query = 1'b1;
								cmd.res_sel = RES_QUERY;
							end
						end
						default: begin
							cmd.res_sel = RES_OK;
						end
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ST_POP: begin
				if (stat.pop_pending) begin
					cmd.pop_take = 1'b1;
					cmd.res_we = 1'b1;
					cmd.res_sel = RES_RUN;
				end
			end
			ST_DONE: begin
				cmd.deliver = !stat.out_busy;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ===== sv/mptd_dpath.sv =====
// Datapath of the dispatcher: level queues, task flags, scan state and the result register.
module mptd_dpath #(
	parameter int NUM_LEVELS = mptd_pkg::DEF_NUM_LEVELS,
	parameter int NUM_TASKS = mptd_pkg::DEF_NUM_TASKS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mptd_pkg::dp_cmd_t             cmd,
	output mptd_pkg::dp_stat_t            stat,
	input  logic [mptd_pkg::ACTION_W-1:0] action,
	input  logic [mptd_pkg::TASK_W-1:0]   task_index,
	input  logic [mptd_pkg::LEVEL_W-1:0]  level,
	input  logic                          more_work,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mptd_pkg::STATUS_W-1:0] status,
	output logic [mptd_pkg::TASK_W-1:0]   run_task,
	output logic                          preempted,
	output logic [mptd_pkg::HLEVEL_W-1:0] higher_level
);
	import mptd_pkg::*;

	localparam int LVL_W = $clog2(NUM_LEVELS);
	localparam int TSK_W = $clog2(NUM_TASKS);
	localparam int CNT_W = $clog2(NUM_TASKS + 1);
	localparam int TOT_W = $clog2(NUM_LEVELS * NUM_TASKS + 1);
	localparam int ADR_W = LVL_W + TSK_W;
	localparam int MEM_DEPTH = 2 ** ADR_W;

	// Latched input beat.
	action_t             action_q;
	logic [TASK_W-1:0]   task_q;
	logic [LEVEL_W-1:0]  level_q;
	logic                more_q;

	// Per-task and per-level state.
	logic [NUM_TASKS-1:0] pending_q;
	logic [HLEVEL_W-1:0]  resume_q [NUM_TASKS];
	logic [LVL_W-1:0]     tlevel_q [NUM_TASKS];
	logic [TSK_W-1:0]     head_q [NUM_LEVELS];
	logic [CNT_W-1:0]     count_q [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] mask_q;
	logic [LVL_W-1:0]     scan_q;
	logic [CNT_W-1:0]     remain_q;
	logic                 loaded_q;
	logic [TOT_W-1:0]     total_q;

	// Queue entries of all levels, addressed by level and slot.
	logic [TSK_W-1:0] fifo_mem [MEM_DEPTH];
	logic [TSK_W-1:0] rdata_q;

	// Result waiting for the output register, and the output register itself.
	logic [STATUS_W-1:0] res_status_q;
	logic [TASK_W-1:0]   res_run_q;
	logic                res_pre_q;
	logic [HLEVEL_W-1:0] res_hl_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [TASK_W-1:0]   run_task_q;
	logic                preempted_q;
	logic [HLEVEL_W-1:0] higher_level_q;

	logic [TSK_W-1:0]    tidx;
	logic [LVL_W-1:0]    lidx;
	logic [LVL_W-1:0]    tlev_raw;
	logic [LVL_W-1:0]    tlev_fix;
	logic [LVL_W-1:0]    enq_lvl;
	logic [LVL_W-1:0]    scan_lvl;
	logic [LVL_W-1:0]    next_scan;
	logic [LVL_W-1:0]    sel_lvl;
	logic [LVL_W-1:0]    jump_lvl;
	logic [HLEVEL_W-1:0] resume_val;
	logic [TSK_W-1:0]    sel_head;
	logic [CNT_W-1:0]    sel_count;
	logic [CNT_W-1:0]    eff_remain;
	logic                scan_pop;
	logic [TSK_W:0]      slot_sum;
	logic [TSK_W-1:0]    slot;
	logic [TSK_W:0]      head_sum;
	logic [TSK_W-1:0]    head_inc;
	logic                do_enq;
	logic [ADR_W-1:0]    wr_addr;
	logic [ADR_W-1:0]    rd_addr;
	logic                q_hit;
	logic [LEVEL_W-1:0]  q_idx;
	logic [STATUS_W-1:0] res_status_d;
	logic [TASK_W-1:0]   res_run_d;
	logic                res_pre_d;
	logic [HLEVEL_W-1:0] res_hl_d;

	assign tidx = TSK_W'(task_q);
	assign lidx = LVL_W'(level_q);
	assign tlev_raw = tlevel_q[tidx];
	assign tlev_fix = (32'(tlev_raw) >= NUM_LEVELS) ? LVL_W'(32'(tlev_raw) - NUM_LEVELS) :
		tlev_raw;
	assign enq_lvl = cmd.enq_from_task ? tlev_fix : lidx;
	assign scan_lvl = (32'(scan_q) >= NUM_LEVELS) ? '0 : scan_q;
	assign next_scan = (32'(scan_lvl) + 1 >= NUM_LEVELS) ? '0 : LVL_W'(32'(scan_lvl) + 1);
	assign sel_lvl = cmd.scan_step ? scan_lvl : enq_lvl;
	assign sel_head = head_q[sel_lvl];
	assign sel_count = count_q[sel_lvl];

	// On entering a level the scan snapshots its length; the snapshot bounds this pass.
	assign eff_remain = loaded_q ? remain_q : sel_count;
	assign scan_pop = (eff_remain != '0) && (sel_count != '0);

	assign slot_sum = (TSK_W + 1)'(sel_head) + (TSK_W + 1)'(sel_count);
	assign slot = (32'(slot_sum) >= NUM_TASKS) ? TSK_W'(32'(slot_sum) - NUM_TASKS) :
		TSK_W'(slot_sum);
	assign head_sum = (TSK_W + 1)'(sel_head) + (TSK_W + 1)'(1);
	assign head_inc = (32'(head_sum) >= NUM_TASKS) ? '0 : TSK_W'(head_sum);

	// A task is queued at most once; a full queue cannot occur but drops the entry.
	assign do_enq = cmd.enqueue && !pending_q[tidx] && (32'(sel_count) < NUM_TASKS);
	assign wr_addr = {enq_lvl, slot};
	assign rd_addr = {scan_lvl, sel_head};

	assign resume_val = resume_q[tidx];
	assign jump_lvl = (32'(resume_val) >= NUM_LEVELS) ? '0 : LVL_W'(resume_val);

	// Lowest-numbered ready level below the queried one; the queried level itself if none.
	always_comb begin
		q_hit = 1'b0;
		q_idx = level_q;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (!q_hit && (i < 32'(level_q)) && mask_q[i]) begin
				q_hit = 1'b1;
				q_idx = LEVEL_W'(i);
			end
		end
	end

	always_comb begin
		res_status_d = STS_OK;
		res_run_d = '0;
		res_pre_d = 1'b0;
		res_hl_d = '0;
		case (cmd.res_sel)
			RES_OK: begin
				res_status_d = STS_OK;
			end
			RES_RANGE: begin
				res_status_d = STS_RANGE;
			end
			RES_EMPTY: begin
				res_status_d = STS_EMPTY;
			end
			RES_QUERY: begin
				res_pre_d = q_hit;
				res_hl_d = HLEVEL_W'(q_idx);
			end
			RES_RUN: begin
				res_run_d = TASK_W'(rdata_q);
			end
			default: begin
				res_status_d = STS_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			for (int i = 0; i < NUM_TASKS; i++) begin
				resume_q[i] <= '0;
			end
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= '0;
				count_q[i] <= '0;
			end
			mask_q <= '0;
			scan_q <= '0;
			remain_q <= '0;
			loaded_q <= 1'b0;
			total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_enq) begin
				pending_q[tidx] <= 1'b1;
				count_q[enq_lvl] <= sel_count + CNT_W'(1);
				mask_q[enq_lvl] <= 1'b1;
				total_q <= total_q + TOT_W'(1);
			end
			if (cmd.jump) begin
				scan_q <= jump_lvl;
				loaded_q <= 1'b0;
			end
			if (cmd.query) begin
				resume_q[tidx] <= HLEVEL_W'(q_idx);
			end
			if (cmd.scan_step) begin
				if (scan_pop) begin
					head_q[scan_lvl] <= head_inc;
					count_q[scan_lvl] <= sel_count - CNT_W'(1);
					remain_q <= eff_remain - CNT_W'(1);
					loaded_q <= 1'b1;
					total_q <= total_q - TOT_W'(1);
					scan_q <= scan_lvl;
				end else begin
					// Snapshot used up: the level drops out of the mask and the scan moves on.
					mask_q[scan_lvl] <= 1'b0;
					scan_q <= next_scan;
					loaded_q <= 1'b0;
				end
			end
			if (cmd.pop_take) begin
				pending_q[rdata_q] <= 1'b0;
			end
			if (cmd.deliver) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			action_q <= action_t'(action);
			task_q <= task_index;
			level_q <= level;
			more_q <= more_work;
		end
		if (do_enq) begin
			tlevel_q[tidx] <= enq_lvl;
			fifo_mem[wr_addr] <= tidx;
		end
		if (cmd.scan_step && scan_pop) begin
			rdata_q <= fifo_mem[rd_addr];
		end
		if (cmd.res_we) begin
			res_status_q <= res_status_d;
			res_run_q <= res_run_d;
			res_pre_q <= res_pre_d;
			res_hl_q <= res_hl_d;
		end
		if (cmd.deliver) begin
			status_q <= res_status_q;
			run_task_q <= res_run_q;
			preempted_q <= res_pre_q;
			higher_level_q <= res_hl_q;
		end
	end

	assign stat.action = action_q;
	assign stat.task_oor = 32'(task_q) >= NUM_TASKS;
	assign stat.level_oor = 32'(level_q) >= NUM_LEVELS;
	assign stat.more = more_q;
	assign stat.queue_empty = (total_q == '0);
	assign stat.scan_pop = scan_pop;
	assign stat.pop_pending = pending_q[rdata_q];
	assign stat.out_busy = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign run_task = run_task_q;
	assign preempted = preempted_q;
	assign higher_level = higher_level_q;

endmodule

// ===== sv/multilevel_priority_task_dispatcher.sv =====
// Top level of the multilevel priority task dispatcher.
// One beat is taken at a time and gives one result beat. Schedule, complete and query beats
// hold the input side while the block accepts, executes and writes the output register. A
// dispatch beat holds it longer for every level that the scan leaves behind, since the scan
// controller looks at one level per cycle and each pop waits for the queue memory's
// registered read. A finished result waits in the output register while the next beat is
// accepted; the block only holds its next result until that register is free. The queue memory
// needs no clearing after reset, so the block is ready at once.
module multilevel_priority_task_dispatcher #(
	parameter int NUM_LEVELS = mptd_pkg::DEF_NUM_LEVELS,
	parameter int NUM_TASKS = mptd_pkg::DEF_NUM_TASKS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mptd_pkg::ACTION_W-1:0] action,
	input  logic [mptd_pkg::TASK_W-1:0]   task_index,
	input  logic [mptd_pkg::LEVEL_W-1:0]  level,
	input  logic                          more_work,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mptd_pkg::STATUS_W-1:0] status,
	output logic [mptd_pkg::TASK_W-1:0]   run_task,
	output logic                          preempted,
	output logic [mptd_pkg::HLEVEL_W-1:0] higher_level
);
	import mptd_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	mptd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	mptd_dpath #(
		.NUM_LEVELS (NUM_LEVELS),
		.NUM_TASKS  (NUM_TASKS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.action       (action),
		.task_index   (task_index),
		.level        (level),
		.more_work    (more_work),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.run_task     (run_task),
		.preempted    (preempted),
		.higher_level (higher_level)
	);

endmodule

// ===== sv/mptd_checker.sv =====
// Port-level checks of the dispatcher and the bind that attaches them to the top level.
module mptd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [mptd_pkg::STATUS_W-1:0] status,
	input logic [mptd_pkg::TASK_W-1:0]   run_task,
	input logic                          preempted,
	input logic [mptd_pkg::HLEVEL_W-1:0] higher_level
);
	import mptd_pkg::*;

	// A result beat that is stalled stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat withdrawn while stalled");

	// The block works on one beat at a time, so it is busy right after taking one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again before the previous beat was executed");

	// A failing item reports nothing but its status.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STS_OK |-> run_task == '0 && !preempted && higher_level == '0)
		else $error("failing result carries payload");

	// A preempting query result never names a task to run and reports success.
	a_query_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && preempted |-> run_task == '0 && status == STS_OK)
		else $error("preemption result mixed with a dispatch result");

endmodule

bind multilevel_priority_task_dispatcher mptd_checker u_mptd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.run_task     (run_task),
	.preempted    (preempted),
	.higher_level (higher_level)
);

// ===== tb/tb_multilevel_priority_task_dispatcher.sv =====
// Self-checking testbench for the multilevel priority task dispatcher.
module tb_multilevel_priority_task_dispatcher;
	timeunit 1ns;
	timeprecision 1ps;

	import mptd_pkg::*;

	localparam int NL = DEF_NUM_LEVELS;
	localparam int NT = DEF_NUM_TASKS;
	localparam int RANDOM_PER_PHASE = 212;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		action_t       act;
		logic [3:0]    tsk;
		logic [3:0]    lvl;
		logic          more;
	} beat_t;

	typedef struct packed {
		status_t       sts;
		logic [3:0]    run;
		logic          pre;
		logic [2:0]    hl;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [ACTION_W-1:0] action = '0;
	logic [TASK_W-1:0] task_index = '0;
	logic [LEVEL_W-1:0] level = '0;
	logic more_work = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [TASK_W-1:0] run_task;
	logic preempted;
	logic [HLEVEL_W-1:0] higher_level;

	// Stimulus side.
	beat_t beats_to_send[$];
	bit level_known[NT];
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit pressure_go = 1'b0;
	bit hold_out = 1'b0;

	// Predicted dispatcher state.
	bit task_waiting[NT];
	int task_level[NT];
	int resume_level[NT];
	int level_queue[NL][NT];
	int queue_head[NL];
	int queue_count[NL];
	bit [NL-1:0] ready_levels = '0;
	int scan_pos = 0;
	int pass_left = 0;
	bit pass_loaded = 1'b0;

	outcome_t predicted_outcomes[$];
	outcome_t oldest_outcome;
	int unsigned error_count = 0;
	int unsigned action_seen[4];
	int unsigned results_checked = 0;

	multilevel_priority_task_dispatcher #(
		.NUM_LEVELS(NL),
		.NUM_TASKS(NT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.task_index(task_index),
		.level(level),
		.more_work(more_work),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.run_task(run_task),
		.preempted(preempted),
		.higher_level(higher_level)
	);

	always #4 clk = ~clk;

	function automatic void queue_task(int t, int lv);
		int slot;
		if (task_waiting[t] || queue_count[lv] >= NT)
			return;
		slot = (queue_head[lv] + queue_count[lv]) % NT;
		level_queue[lv][slot] = t;
		queue_count[lv]++;
		task_waiting[t] = 1'b1;
		task_level[t] = lv;
		ready_levels[lv] = 1'b1;
	endfunction

	// Resumes the cyclic scan; returns the task to run, or -1 when nothing is queued.
	function automatic int pick_queued_task();
		int total;
		int lv;
		int t;
		total = 0;
		for (int l = 0; l < NL; l++)
			total += queue_count[l];
		if (total == 0)
			return -1;
		for (int it = 0; it < 4 * NL + 4 * NT + 4; it++) begin
			lv = scan_pos;
			if (lv >= NL) begin
				scan_pos = 0;
				lv = 0;
			end
			if (!pass_loaded) begin
				pass_left = queue_count[lv];
				pass_loaded = 1'b1;
			end
			if (pass_left > 0 && queue_count[lv] > 0) begin
				t = level_queue[lv][queue_head[lv]] % NT;
				queue_head[lv] = (queue_head[lv] + 1) % NT;
				queue_count[lv]--;
				pass_left--;
				if (task_waiting[t]) begin
					task_waiting[t] = 1'b0;
					return t;
				end
			end else begin
				ready_levels[lv] = 1'b0;
				scan_pos = (lv + 1 >= NL) ? 0 : lv + 1;
				pass_loaded = 1'b0;
			end
		end
		return -1;
	endfunction

	function automatic outcome_t predict_outcome(action_t act, logic [3:0] tsk, logic [3:0] lvl,
			logic more);
		outcome_t res;
		int picked;
		int hit;
		int r;
		res = '0;
		res.sts = STS_OK;
		if (act == ACT_DISPATCH) begin
			picked = pick_queued_task();
			if (picked < 0)
				res.sts = STS_EMPTY;
			else
				res.run = picked[3:0];
		end else if (tsk >= NT) begin
			res.sts = STS_EMPTY;
		end else if (act == ACT_SCHEDULE) begin
			if (lvl >= NL)
				res.sts = STS_RANGE;
			else
				queue_task(int'(tsk), int'(lvl));
		end else if (act == ACT_COMPLETE) begin
			if (more) begin
				r = resume_level[tsk];
				queue_task(int'(tsk), task_level[tsk] % NL);
				scan_pos = (r >= NL) ? 0 : r;
				pass_loaded = 1'b0;
			end
		end else begin
			if (lvl >= NL) begin
				res.sts = STS_RANGE;
			end else begin
				// Walk downward so the lowest ready level below lvl wins.
				hit = int'(lvl);
				for (int k = NL - 1; k >= 0; k--)
					if (k < lvl && ready_levels[k])
						hit = k;
				resume_level[tsk] = hit & 7;
				res.pre = (hit != lvl);
				res.hl = hit[2:0];
			end
		end
		return res;
	endfunction

	function automatic void add_beat(action_t act, int t, int l, bit m);
		beat_t b;
		b.act = act;
		b.tsk = t[3:0];
		b.lvl = l[3:0];
		b.more = m;
		if (act == ACT_SCHEDULE && l < NL)
			level_known[t] = 1'b1;
		beats_to_send.push_back(b);
	endfunction

	// Mostly well-formed traffic; a completion with more work only for tasks that have a level.
	function automatic void add_random_beat();
		int r;
		int t;
		int l;
		bit m;
		r = $urandom_range(99);
		t = $urandom_range(NT - 1);
		l = $urandom_range(15);
		m = ($urandom_range(1) != 0);
		if (r < 30) begin
			l = ($urandom_range(9) == 0) ? $urandom_range(15, NL) : $urandom_range(NL - 1);
			add_beat(ACT_SCHEDULE, t, l, m);
		end else if (r < 65) begin
			add_beat(ACT_DISPATCH, t, l, m);
		end else if (r < 85) begin
			m = ($urandom_range(3) != 0);
			if (m && !level_known[t])
				m = 1'b0;
			add_beat(ACT_COMPLETE, t, l, m);
		end else begin
			l = ($urandom_range(9) == 0) ? $urandom_range(15, NL) : $urandom_range(NL - 1);
			add_beat(ACT_QUERY, t, l, m);
		end
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endfunction

	// Driver: a new beat goes out only once the current one has been taken.
	always @(posedge clk) begin
		if (arst_n && (!in_valid || !in_stall)) begin
			if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				action <= beats_to_send[0].act;
				task_index <= beats_to_send[0].tsk;
				level <= beats_to_send[0].lvl;
				more_work <= beats_to_send[0].more;
				beats_to_send.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			out_stall <= hold_out || ($urandom_range(99) < recv_stall_pct);
	end

	// Monitor: predict on each accepted input beat, check each accepted result beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predicted_outcomes.push_back(predict_outcome(action_t'(action), task_index, level,
					more_work));
				action_seen[action]++;
			end
			if (out_valid && !out_stall) begin
				if (predicted_outcomes.size() == 0) begin
					$display("%0t: result beat with nothing expected, actual status %0d run_task %0d",
						$time, status, run_task);
					error_count++;
				end else begin
					oldest_outcome = predicted_outcomes.pop_front();
					check_field("status", 32'(oldest_outcome.sts), 32'(status));
					check_field("run_task", 32'(oldest_outcome.run), 32'(run_task));
					check_field("preempted", 32'(oldest_outcome.pre), 32'(preempted));
					check_field("higher_level", 32'(oldest_outcome.hl), 32'(higher_level));
					results_checked++;
				end
			end
		end
	end

	// Long output hold so the block backs up and stalls its input.
	initial begin
		wait (pressure_go);
		@(negedge clk);
		hold_out = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_out = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opening: empty dispatch, range errors, repeats, jumps and drain.
		add_beat(ACT_DISPATCH, 15, 15, 1'b1);
		add_beat(ACT_QUERY, 0, 0, 1'b0);
		add_beat(ACT_QUERY, 15, NL - 1, 1'b1);
		add_beat(ACT_QUERY, 3, 15, 1'b0);
		add_beat(ACT_SCHEDULE, 0, NL - 1, 1'b0);
		add_beat(ACT_SCHEDULE, 15, 0, 1'b1);
		add_beat(ACT_SCHEDULE, 5, 3, 1'b0);
		add_beat(ACT_SCHEDULE, 5, 6, 1'b0);
		add_beat(ACT_SCHEDULE, 3, NL, 1'b0);
		add_beat(ACT_SCHEDULE, 9, 15, 1'b1);
		add_beat(ACT_QUERY, 0, NL - 1, 1'b0);
		add_beat(ACT_QUERY, 5, 3, 1'b1);
		add_beat(ACT_COMPLETE, 9, 0, 1'b0);
		add_beat(ACT_DISPATCH, 0, 0, 1'b0);
		add_beat(ACT_COMPLETE, 15, 0, 1'b1);
		add_beat(ACT_COMPLETE, 0, 0, 1'b1);
		add_beat(ACT_DISPATCH, 0, 0, 1'b0);
		add_beat(ACT_QUERY, 15, 5, 1'b0);
		add_beat(ACT_DISPATCH, 0, 0, 1'b0);
		add_beat(ACT_DISPATCH, 0, 0, 1'b0);
		add_beat(ACT_DISPATCH, 0, 0, 1'b0);
		add_beat(ACT_DISPATCH, 0, 0, 1'b0);
		add_beat(ACT_COMPLETE, 5, 0, 1'b1);
		add_beat(ACT_SCHEDULE, 12, 2, 1'b1);
		add_beat(ACT_DISPATCH, 15, 15, 1'b1);

		for (int phase = 0; phase < 4; phase++) begin
			while (beats_to_send.size() != 0 || in_valid || predicted_outcomes.size() != 0)
				@(negedge clk);
			case (phase)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 49;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 49;
				pressure_go = 1'b1;
			end
			default: begin
				send_idle_pct = 12;
				recv_stall_pct = 12;
			end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				add_random_beat();
		end

		while (beats_to_send.size() != 0 || in_valid || predicted_outcomes.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);

		$display("Checked %0d results: %0d schedule, %0d dispatch, %0d complete, %0d query beats,",
			results_checked, action_seen[ACT_SCHEDULE], action_seen[ACT_DISPATCH],
			action_seen[ACT_COMPLETE], action_seen[ACT_QUERY]);
		$display("under free flow, sender gaps, receiver stalls with a long hold, and mixed idling.");
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
